FILE: rtl/core/otq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package otq_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] when_time;
        logic [47:0] repeat_interval;
        logic [3:0]  target_slot;
        logic [31:0] target_tag;
        logic [47:0] now_time;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] tag;
        logic        earliest_changed;
        logic        rearmed;
        logic        next_valid;
        logic [47:0] next_expiry;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [47:0] expiry;
        logic [47:0] interval;
        logic [31:0] tag;
    } t_entry;

    typedef enum logic {
        SCAN_ALL,
        SCAN_DUE
    } t_scan_mode;

    typedef struct packed {
        logic fin;
        logic found;
    } t_scan_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_WR,
        S_CAN_RD,
        S_CAN_CHK,
        S_TICK_SCAN,
        S_TICK_PROC,
        S_SUM_SCAN
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/otq_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module otq_mem import otq_pkg::*; #(
    parameter int N  = 16,
    parameter int SW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [SW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [SW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [N];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/otq_scan.sv
`timescale 1ns / 1ps
`default_nettype none
module otq_scan import otq_pkg::*; #(
    parameter int N  = 16,
    parameter int SW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire t_scan_mode    i_mode,
    input  wire logic [47:0]   i_now,
    input  wire logic [N-1:0]  i_used,
    input  wire logic [N-1:0]  i_done,
    input  wire t_entry        i_rdata,
    output logic               o_rd,
    output logic [SW-1:0]      o_addr,
    output t_scan_stat         o_stat,
    output logic [SW-1:0]      o_best_idx,
    output t_entry             o_best
);

    logic          r_run;
    logic          r_dv;
    logic          r_fin;
    logic          r_found;
    logic [SW-1:0] r_cnt;
    logic [SW-1:0] r_didx;
    logic [SW-1:0] r_bidx;
    t_entry        r_best;
    t_scan_mode    r_mode;
    logic          w_cand;
    logic          w_take;

    // candidate filter and strict-less min, ties keep the lower slot
    assign w_cand = i_used[r_didx] &&
        (r_mode == SCAN_ALL || (!i_done[r_didx] && i_rdata.expiry <= i_now));
    assign w_take = r_dv && w_cand && (!r_found || i_rdata.expiry < r_best.expiry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_dv    <= 1'b0;
            r_fin   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_fin <= r_dv && (r_didx == SW'(N - 1));
            r_dv  <= r_run;
            if (i_go) begin
                r_run   <= 1'b1;
                r_found <= 1'b0;
            end else begin
                if (r_run && r_cnt == SW'(N - 1)) begin
                    r_run <= 1'b0;
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_cnt  <= '0;
            r_mode <= i_mode;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_didx <= r_cnt;
        if (w_take) begin
            r_bidx <= r_didx;
            r_best <= i_rdata;
        end
    end

    assign o_rd       = r_run;
    assign o_addr     = r_cnt;
    assign o_stat     = '{fin: r_fin, found: r_found};
    assign o_best_idx = r_bidx;
    assign o_best     = r_best;

endmodule
`default_nettype wire

FILE: rtl/core/ordered_timer_queue_top.sv
// ordered timer queue
// input: one command beat is taken when i_start is high and o_busy is low;
// i_cmd carries add, cancel or tick with its fields. command code 3 is dropped.
// output: each result beat shows on o_res for one cycle with o_res_stb high;
// the receiver cannot stall, so no result is held back. o_res.last marks the
// final beat of a command.
// work per command:
//   add     one sweep of the slot memory for the earliest expiry
//   cancel  one memory read of the slot tag
//   tick    every expired timer costs one full sweep of the slot memory to
//           find the next earliest, a sweep that finds none ends the
//           search, and a last sweep yields the summary
// the memory has one read port with a registered read; sweeps read one
// slot per cycle.
// o_busy stays high from an accepted add, cancel or tick beat until the last
// result beat is on o_res; a new beat can be taken in that same cycle.
// reset clears all slot-used bits and the tag counter; the slot memory itself
// is not cleared, entries are only used for slots in use.
`timescale 1ns / 1ps
`default_nettype none
module ordered_timer_queue_top import otq_pkg::*; #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    output logic      o_busy,
    output logic      o_res_stb,
    output t_res      o_res
);

    localparam int SW = $clog2(TIMER_SLOTS);
    localparam int IW = (SW >= 4) ? SW + 1 : 5;

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [TIMER_SLOTS-1:0] r_used, n_used;
    logic [TIMER_SLOTS-1:0] r_done, n_done;
    logic [31:0]         r_next_tag, n_next_tag;
    logic                r_stb, n_stb;
    t_res                r_res, n_res;

    logic                w_accept;
    logic                w_go;
    t_scan_mode          w_mode;
    logic                w_we;
    logic [SW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic                w_can_re;
    logic                w_re;
    logic [SW-1:0]       w_raddr;
    t_entry              w_rdata;
    logic                w_scan_rd;
    logic [SW-1:0]       w_scan_addr;
    t_scan_stat          w_stat;
    logic [SW-1:0]       w_bidx;
    t_entry              w_best;
    logic [SW-1:0]       w_free;
    logic                w_full;
    logic [48:0]         w_sum;
    logic [47:0]         w_rearm;
    logic [IW-1:0]       w_tw;
    logic                w_inr;
    logic [SW-1:0]       w_tidx;
    logic                w_hit;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        w_free = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free = SW'(i);
            end
        end
    end
    assign w_full = &r_used;

    assign w_sum   = {1'b0, r_cmd.now_time} + {1'b0, w_best.interval};
    assign w_rearm = w_sum[48] ? TIME_MAX : w_sum[47:0];

    assign w_tw   = IW'(r_cmd.target_slot);
    assign w_inr  = w_tw < IW'(TIMER_SLOTS);
    assign w_tidx = w_tw[SW-1:0];
    assign w_hit  = w_inr && r_used[w_tidx] && (w_rdata.tag == r_cmd.target_tag);

    assign w_re    = w_scan_rd || w_can_re;
    assign w_raddr = w_can_re ? w_tidx : w_scan_addr;

    otq_mem #(.N(TIMER_SLOTS), .SW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    otq_scan #(.N(TIMER_SLOTS), .SW(SW)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_mode     (w_mode),
        .i_now      (r_cmd.now_time),
        .i_used     (r_used),
        .i_done     (r_done),
        .i_rdata    (w_rdata),
        .o_rd       (w_scan_rd),
        .o_addr     (w_scan_addr),
        .o_stat     (w_stat),
        .o_best_idx (w_bidx),
        .o_best     (w_best)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.command)
                        CMD_ADD:    n_state = S_ADD_SCAN;
                        CMD_CANCEL: n_state = S_CAN_RD;
                        CMD_TICK:   n_state = S_TICK_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN:  if (w_stat.fin) n_state = S_ADD_WR;
            S_ADD_WR:    n_state = S_IDLE;
            S_CAN_RD:    n_state = S_CAN_CHK;
            S_CAN_CHK:   n_state = S_IDLE;
            S_TICK_SCAN: begin
                if (w_stat.fin) begin
                    n_state = w_stat.found ? S_TICK_PROC : S_SUM_SCAN;
                end
            end
            S_TICK_PROC: n_state = S_TICK_SCAN;
            S_SUM_SCAN:  if (w_stat.fin) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_stb      = 1'b0;
        n_res      = '0;
        n_used     = r_used;
        n_done     = r_done;
        n_next_tag = r_next_tag;
        w_go       = 1'b0;
        w_mode     = SCAN_ALL;
        w_we       = 1'b0;
        w_waddr    = w_free;
        w_wdata    = '{expiry: r_cmd.when_time, interval: r_cmd.repeat_interval,
                       tag: r_next_tag + 32'd1};
        w_can_re   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_cmd.command == CMD_ADD) begin
                    w_go = 1'b1;
                end
                if (w_accept && i_cmd.command == CMD_TICK) begin
                    w_go   = 1'b1;
                    w_mode = SCAN_DUE;
                    n_done = '0;
                end
            end
            S_ADD_WR: begin
                n_stb      = 1'b1;
                n_res.kind = KIND_ADD;
                n_res.last = 1'b1;
                if (w_full) begin
                    n_res.status = STAT_FULL;
                end else begin
                    w_we                   = 1'b1;
                    n_used[w_free]         = 1'b1;
                    n_next_tag             = r_next_tag + 32'd1;
                    n_res.slot             = 4'(w_free);
                    n_res.tag              = r_next_tag + 32'd1;
                    n_res.earliest_changed = !w_stat.found ||
                                             (r_cmd.when_time < w_best.expiry);
                end
            end
            S_CAN_RD: begin
                w_can_re = w_inr;
            end
            S_CAN_CHK: begin
                n_stb        = 1'b1;
                n_res.kind   = KIND_CANCEL;
                n_res.slot   = r_cmd.target_slot;
                n_res.tag    = r_cmd.target_tag;
                n_res.last   = 1'b1;
                n_res.status = w_hit ? STAT_OK : STAT_NOT_FOUND;
                if (w_hit) begin
                    n_used[w_tidx] = 1'b0;
                end
            end
            S_TICK_SCAN: begin
                if (w_stat.fin && !w_stat.found) begin
                    w_go = 1'b1;
                end
            end
            S_TICK_PROC: begin
                n_stb          = 1'b1;
                n_res.kind     = KIND_EXPIRED;
                n_res.slot     = 4'(w_bidx);
                n_res.tag      = w_best.tag;
                n_res.rearmed  = (w_best.interval != '0);
                n_done[w_bidx] = 1'b1;
                w_waddr        = w_bidx;
                w_wdata        = '{expiry: w_rearm, interval: w_best.interval,
                                   tag: w_best.tag};
                if (w_best.interval != '0) begin
                    w_we = 1'b1;
                end else begin
                    n_used[w_bidx] = 1'b0;
                end
                w_go   = 1'b1;
                w_mode = SCAN_DUE;
            end
            S_SUM_SCAN: begin
                if (w_stat.fin) begin
                    n_stb            = 1'b1;
                    n_res.kind       = KIND_SUMMARY;
                    n_res.last       = 1'b1;
                    n_res.next_valid = w_stat.found;
                    n_res.next_expiry = w_stat.found ? w_best.expiry : '0;
                end
            end
            default: begin
                n_stb = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_done     <= '0;
            r_next_tag <= '0;
            r_stb      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_done     <= n_done;
            r_next_tag <= n_next_tag;
            r_stb      <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        r_res <= n_res;
    end

    assign o_res_stb = r_stb;
    assign o_res     = r_res;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.command == CMD_ADD || i_cmd.command == CMD_CANCEL ||
         i_cmd.command == CMD_TICK)) |=> o_busy)
        else $error("accepted beat did not raise busy");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && o_res.kind == KIND_SUMMARY) |-> o_res.last)
        else $error("summary beat without last");

    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_stb && o_res.kind == KIND_EXPIRED) |-> !o_res.last)
        else $error("expired beat marked last");

    a_idle_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !w_scan_rd)
        else $error("slot sweep running while idle");

endmodule
`default_nettype wire
